### design/bpcw_pkg.sv
// Shared types, constants and bit-level helpers for the CRC-24 / whitening block.
// No dependencies.
package bpcw_pkg;

    localparam logic [23:0] CRC_POLY      = 24'hDA6000;
    localparam logic [6:0]  WHITEN_SET    = 7'h40;
    localparam logic [5:0]  CHANNEL_RST   = 6'd37;
    localparam logic [23:0] CRC_INIT_RST  = 24'hAAAAAA;
    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL = 2'd0,
        CFG_CRC_INIT = 2'd1,
        CFG_REVERSE = 2'd2,
        CFG_WHITEN = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_PAYLOAD = 2'd0,
        BK_CRC0    = 2'd1,
        BK_CRC1    = 2'd2,
        BK_CRC2    = 2'd3
    } t_back_state;

    typedef struct packed {
        logic [5:0]  channel_index;
        logic [23:0] crc_init;
        logic        reverse_enable;
        logic        whiten_enable;
    } t_cfg;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // One queued payload byte with everything the back end needs.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  wbits;
        logic        frame_end;
        logic [23:0] crc;
        logic [6:0]  lfsr;
    } t_entry;

    typedef struct packed {
        logic [6:0] state;
        logic [7:0] bits;
    } t_whiten;

    function automatic logic [23:0] crc_step8(input logic [23:0] crc_in,
                                              input logic [7:0] d);
        logic [23:0] c;
        logic        t;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            t = c[0];
            c = {1'b0, c[23:1]};
            if (t != d[i]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_whiten whiten_step8(input logic [6:0] w_in);
        t_whiten r;
        logic [6:0] w;
        logic       b;
        w = w_in;
        r.bits = 8'h00;
        for (int i = 0; i < 8; i++) begin
            b = w[0];
            r.bits[i] = b;
            w = {b, w[6:4], w[3] ^ b, w[2:1]};
        end
        r.state = w;
        return r;
    endfunction

    function automatic logic [7:0] encode(input logic [7:0] b, input logic [7:0] w,
                                          input logic wen, input logic ren);
        logic [7:0] x;
        logic [7:0] r;
        x = wen ? (b ^ w) : b;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = x[i];
        end
        return ren ? r : x;
    endfunction

endpackage

### design/bpcw_front.sv
// Front end: takes PDU bytes; steps CRC, whitening one byte a cycle unless queue full.
// Depends on bpcw_pkg.
module bpcw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpcw_pkg::t_cfg    i_cfg,
    input  bpcw_pkg::t_cfg_wr i_cfg_wr,
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_end,
    input  logic              i_q_full,
    output logic              o_push,
    output bpcw_pkg::t_entry  o_entry
);

    logic [23:0]       r_crc, n_crc;
    logic [6:0]        r_whiten, n_whiten;
    bpcw_pkg::t_whiten w_wh;
    logic [23:0]       w_crc_next;

    assign o_push     = i_in_valid && !i_q_full;
    assign w_crc_next = bpcw_pkg::crc_step8(r_crc, i_data_byte);
    assign w_wh       = bpcw_pkg::whiten_step8(r_whiten);

    always_comb begin
        o_entry.data_byte = i_data_byte;
        o_entry.wbits     = w_wh.bits;
        o_entry.frame_end = i_frame_end;
        o_entry.crc       = w_crc_next;
        o_entry.lfsr      = w_wh.state;
    end

    always_comb begin
        n_crc    = r_crc;
        n_whiten = r_whiten;
        if (o_push) begin
            if (i_frame_end) begin
                n_crc    = i_cfg.crc_init;
                n_whiten = bpcw_pkg::WHITEN_SET | {1'b0, i_cfg.channel_index};
            end else begin
                n_crc    = w_crc_next;
                n_whiten = w_wh.state;
            end
        end
        if (i_cfg_wr.we) begin
            case (i_cfg_wr.idx)
                bpcw_pkg::CFG_CHANNEL: begin
                    n_whiten = bpcw_pkg::WHITEN_SET | {1'b0, i_cfg_wr.data[5:0]};
                end
                bpcw_pkg::CFG_CRC_INIT: begin
                    n_crc = i_cfg_wr.data[23:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= bpcw_pkg::CRC_INIT_RST;
            r_whiten <= bpcw_pkg::WHITEN_SET | {1'b0, bpcw_pkg::CHANNEL_RST};
        end else begin
            r_crc    <= n_crc;
            r_whiten <= n_whiten;
        end
    end

endmodule

### design/bpcw_fifo.sv
// Short queue of pending byte transactions between front and back ends.
// Depends on bpcw_pkg.
module bpcw_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bpcw_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output bpcw_pkg::t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bpcw_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### design/bpcw_back.sv
// Back end: emits the payload byte and, at frame end, the three CRC bytes.
// Depends on bpcw_pkg; drives the output register.
module bpcw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpcw_pkg::t_cfg   i_cfg,
    input  logic             i_q_empty,
    input  bpcw_pkg::t_entry i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_is_crc,
    output logic             o_last_out
);

    bpcw_pkg::t_back_state r_state, n_state;
    logic [23:0]           r_crc, n_crc;
    logic [6:0]            r_lfsr, n_lfsr;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_byte, n_out_byte;
    logic                  r_is_crc, n_is_crc;
    logic                  r_last, n_last;
    logic                  w_load;
    logic                  w_emit;
    logic [7:0]            w_crc_byte;
    bpcw_pkg::t_whiten     w_wh;

    assign w_load = !r_out_valid || !i_out_stall;
    assign w_wh   = bpcw_pkg::whiten_step8(r_lfsr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bpcw_pkg::BK_PAYLOAD: begin
                if (w_load && !i_q_empty && i_head.frame_end) begin
                    n_state = bpcw_pkg::BK_CRC0;
                end
            end
            bpcw_pkg::BK_CRC0: if (w_load) n_state = bpcw_pkg::BK_CRC1;
            bpcw_pkg::BK_CRC1: if (w_load) n_state = bpcw_pkg::BK_CRC2;
            bpcw_pkg::BK_CRC2: if (w_load) n_state = bpcw_pkg::BK_PAYLOAD;
            default: n_state = bpcw_pkg::BK_PAYLOAD;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_emit     = 1'b1;
        w_crc_byte = r_crc[7:0];
        n_crc      = r_crc;
        n_lfsr     = r_lfsr;
        n_is_crc   = 1'b1;
        n_last     = 1'b0;
        case (r_state)
            bpcw_pkg::BK_PAYLOAD: begin
                w_emit   = !i_q_empty;
                o_pop    = w_load && !i_q_empty;
                n_is_crc = 1'b0;
                if (o_pop) begin
                    n_crc  = i_head.crc;
                    n_lfsr = i_head.lfsr;
                end
            end
            bpcw_pkg::BK_CRC0: w_crc_byte = r_crc[7:0];
            bpcw_pkg::BK_CRC1: w_crc_byte = r_crc[15:8];
            bpcw_pkg::BK_CRC2: begin
                w_crc_byte = r_crc[23:16];
                n_last     = 1'b1;
            end
            default: w_emit = 1'b0;
        endcase
        if (r_state == bpcw_pkg::BK_PAYLOAD) begin
            n_out_byte = bpcw_pkg::encode(i_head.data_byte, i_head.wbits,
                                          i_cfg.whiten_enable, i_cfg.reverse_enable);
        end else begin
            n_out_byte = bpcw_pkg::encode(w_crc_byte, w_wh.bits,
                                          i_cfg.whiten_enable, i_cfg.reverse_enable);
            if (w_load) begin
                n_lfsr = w_wh.state;
            end
        end
        n_out_valid = w_load ? w_emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_lfsr <= n_lfsr;
        if (w_load) begin
            r_out_byte <= n_out_byte;
            r_is_crc   <= n_is_crc;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpcw_pkg::BK_PAYLOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_crc    = r_is_crc;
    assign o_last_out  = r_last;

endmodule

### design/ble_packet_crc_whitener.sv
// Top level: BLE link-layer CRC-24 and whitening; holds the configuration registers.
// Depends on bpcw_pkg, bpcw_front, bpcw_fifo, bpcw_back.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_data_byte, i_frame_end
//   output    out        o_out_valid / i_out_stall o_out_byte, o_is_crc, o_last_out
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One byte a cycle is taken while the queue is not full; CRC and whitening advance eight
// bits per cycle in the front end. A byte with frame end yields four output transactions,
// so the back end lags; the queue absorbs it. Results pass through queue and output register.
// Synchronous active-low reset; the output register stalls independently of the input side.
module ble_packet_crc_whitener #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_frame_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_is_crc,
    output logic                            o_last_out,
    input  logic                            i_cfg_we,
    input  logic [bpcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bpcw_pkg::t_cfg    r_cfg, n_cfg;
    bpcw_pkg::t_cfg_wr w_cfg_wr;
    bpcw_pkg::t_entry  w_entry, w_head;
    logic              w_push, w_pop, w_full, w_empty;

    assign w_cfg_wr.we   = i_cfg_we;
    assign w_cfg_wr.idx  = bpcw_pkg::t_cfg_idx'(i_cfg_idx);
    assign w_cfg_wr.data = i_cfg_data;

    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_wr.we) begin
            case (w_cfg_wr.idx)
                bpcw_pkg::CFG_CHANNEL:  n_cfg.channel_index  = i_cfg_data[5:0];
                bpcw_pkg::CFG_CRC_INIT: n_cfg.crc_init       = i_cfg_data[23:0];
                bpcw_pkg::CFG_REVERSE:  n_cfg.reverse_enable = i_cfg_data[0];
                bpcw_pkg::CFG_WHITEN:   n_cfg.whiten_enable  = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_index  <= bpcw_pkg::CHANNEL_RST;
            r_cfg.crc_init       <= bpcw_pkg::CRC_INIT_RST;
            r_cfg.reverse_enable <= 1'b1;
            r_cfg.whiten_enable  <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_in_stall = w_full;

    bpcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (w_cfg_wr),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    bpcw_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    bpcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_crc    (o_is_crc),
        .o_last_out  (o_last_out)
    );

endmodule

### verif/ble_packet_crc_whitener_tb.sv
// Self-checking testbench for ble_packet_crc_whitener: CRC-24 and whitening of PDU bytes.
// Depends on bpcw_pkg and the ble_packet_crc_whitener RTL; an in-bench predictor builds the
// expected air bytes, and a checker compares every output transaction against them.
module ble_packet_crc_whitener_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [7:0] WHITEN_TAP  = 8'h88;

    typedef struct packed {
        logic [7:0] octet;
        logic       is_crc;
        logic       last;
    } t_air_byte;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    logic [7:0]                      i_data_byte = 8'h00;
    logic                            i_frame_end = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [7:0]                      o_out_byte;
    logic                            o_is_crc;
    logic                            o_last_out;
    logic                            i_cfg_we    = 1'b0;
    bpcw_pkg::t_cfg_idx              i_cfg_idx   = bpcw_pkg::CFG_CHANNEL;
    logic [bpcw_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state and register copy
    logic [5:0]  cfg_channel;
    logic [23:0] cfg_crc_init;
    logic        cfg_rev;
    logic        cfg_wen;
    logic [23:0] crc_state;
    logic [6:0]  wht_state;

    t_air_byte air_q[$];
    int        n_mismatch = 0;
    int        cycle_cnt  = 0;
    int        frame_left = 0;
    bit        idle_on    = 1'b1;

    ble_packet_crc_whitener i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_crc    (o_is_crc),
        .o_last_out  (o_last_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [23:0] crc24_feed(input logic [23:0] c, input logic [7:0] d);
        logic [23:0] r;
        logic        lsb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            lsb = r[0];
            r = r >> 1;
            if (lsb != d[i]) begin
                r = r ^ bpcw_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] next_whiten_bits();
        logic [7:0] bits;
        logic [7:0] t;
        for (int i = 0; i < 8; i++) begin
            bits[i] = wht_state[0];
            t = {1'b0, wht_state};
            if (wht_state[0]) begin
                t = t ^ WHITEN_TAP;
            end
            wht_state = t[7:1];
        end
        return bits;
    endfunction

    function automatic logic [7:0] encode_air(input logic [7:0] b);
        logic [7:0] w;
        logic [7:0] x;
        logic [7:0] r;
        w = next_whiten_bits();
        x = cfg_wen ? (b ^ w) : b;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = x[i];
        end
        return cfg_rev ? r : x;
    endfunction

    function automatic void reload_frame();
        crc_state = cfg_crc_init;
        wht_state = bpcw_pkg::WHITEN_SET | {1'b0, cfg_channel};
    endfunction

    function automatic void predict_byte(input logic [7:0] d, input logic fe);
        t_air_byte a;
        crc_state = crc24_feed(crc_state, d);
        a.octet  = encode_air(d);
        a.is_crc = 1'b0;
        a.last   = 1'b0;
        air_q.push_back(a);
        if (fe) begin
            for (int k = 0; k < 3; k++) begin
                a.octet  = encode_air(crc_state[8*k +: 8]);
                a.is_crc = 1'b1;
                a.last   = (k == 2);
                air_q.push_back(a);
            end
            reload_frame();
        end
    endfunction

    task automatic write_reg(input bpcw_pkg::t_cfg_idx idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            bpcw_pkg::CFG_CHANNEL: begin
                cfg_channel = val[5:0];
                wht_state = bpcw_pkg::WHITEN_SET | {1'b0, cfg_channel};
            end
            bpcw_pkg::CFG_CRC_INIT: begin
                cfg_crc_init = val;
                crc_state = val;
            end
            bpcw_pkg::CFG_REVERSE: cfg_rev = val[0];
            bpcw_pkg::CFG_WHITEN:  cfg_wen = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic fe);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_byte(d, fe);
    endtask

    // stop sending and let every expected byte come out
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (air_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_frames(input int n_items, input int max_len);
        for (int n = 0; n < n_items; n++) begin
            if (frame_left == 0) begin
                frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                                         : $urandom_range(1, max_len);
            end
            send_byte(8'($urandom_range(0, 255)), frame_left == 1);
            frame_left--;
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h3C, 1'b1);
        drain();
    endtask

    // register writes reload the CRC and whitening state inside a frame
    task automatic test_mid_frame_config();
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'h7F, 1'b0);
        drain();
        write_reg(bpcw_pkg::CFG_CRC_INIT, 24'h123456);
        write_reg(bpcw_pkg::CFG_CHANNEL, 24'd12);
        send_byte(8'hC3, 1'b0);
        drain();
        write_reg(bpcw_pkg::CFG_WHITEN, 24'd0);
        send_byte(8'h01, 1'b1);
        drain();
    endtask

    task automatic test_config_extremes();
        logic [5:0]  chans[6] = '{6'd0, 6'd39, 6'd63, 6'd1, 6'd40, 6'd37};
        logic [23:0] inits[6] = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                                  24'h555555, 24'hAAAAAA};
        for (int s = 0; s < 6; s++) begin
            write_reg(bpcw_pkg::CFG_CHANNEL, {18'h3FFFF, chans[s]});
            write_reg(bpcw_pkg::CFG_CRC_INIT, inits[s]);
            write_reg(bpcw_pkg::CFG_REVERSE, {23'h7FFFFF, s[0]});
            write_reg(bpcw_pkg::CFG_WHITEN, {23'h0, s[1]});
            send_byte((s % 2) ? 8'hFF : 8'h00, 1'b0);
            send_byte(8'hA5 ^ s[7:0], 1'b1);
            drain();
        end
    endtask

    task automatic test_random_traffic();
        logic [23:0] v;
        for (int ph = 0; ph < 6; ph++) begin
            v = 24'($urandom());
            case ($urandom_range(0, 3))
                0: v[5:0] = 6'd0;
                1: v[5:0] = 6'd39;
                default: ;
            endcase
            write_reg(bpcw_pkg::CFG_CHANNEL, v);
            write_reg(bpcw_pkg::CFG_CRC_INIT, 24'($urandom()));
            write_reg(bpcw_pkg::CFG_REVERSE, 24'($urandom()));
            write_reg(bpcw_pkg::CFG_WHITEN, 24'($urandom()));
            run_frames(40, 12);
            drain();
        end
    endtask

    // back-to-back frames, mostly short, with no idling on either side
    task automatic test_streaming_no_idle();
        idle_on = 1'b0;
        write_reg(bpcw_pkg::CFG_CHANNEL, 24'd37);
        write_reg(bpcw_pkg::CFG_CRC_INIT, 24'hAAAAAA);
        write_reg(bpcw_pkg::CFG_REVERSE, 24'd1);
        write_reg(bpcw_pkg::CFG_WHITEN, 24'd1);
        run_frames(60, 3);
        drain();
    endtask

    initial begin
        cfg_channel  = bpcw_pkg::CHANNEL_RST;
        cfg_crc_init = bpcw_pkg::CRC_INIT_RST;
        cfg_rev      = 1'b1;
        cfg_wen      = 1'b1;
        reload_frame();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_mid_frame_config();
        test_config_extremes();
        test_random_traffic();
        test_streaming_no_idle();
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("PASS ble_packet_crc_whitener");
        end else begin
            $display("FAIL ble_packet_crc_whitener");
        end
        $finish;
    end

    // receiver stall bursts, with quiet stretches in between
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_air_byte e;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (air_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected transaction: byte %02h is_crc %b last %b",
                             o_out_byte, o_is_crc, o_last_out);
                end
            end else begin
                e = air_q.pop_front();
                if (o_out_byte !== e.octet || o_is_crc !== e.is_crc
                        || o_last_out !== e.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display({"mismatch: byte exp %02h act %02h, ",
                                  "is_crc exp %b act %b, last exp %b act %b"},
                                 e.octet, o_out_byte, e.is_crc, o_is_crc,
                                 e.last, o_last_out);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL ble_packet_crc_whitener");
            $finish;
        end
    end

endmodule
